// File: sv/bce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade equalizer package
// Types, constants and codes shared by the equalizer modules.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int CHANNELS    = 8;
    localparam int SECTIONS    = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int INT_BITS    = SAMPLE_BITS + 8;
    localparam int GAIN_BITS   = 24;
    localparam int GAIN_FRAC   = 20;
    localparam int COEF_FRAC   = COEF_BITS - 6;
    localparam int NCOEF       = 5;
    localparam int CH_BITS     = 3;
    localparam int SEC_BITS    = 6;
    localparam int SEL_BITS    = 3;
    localparam int ACT_BITS    = 7;
    localparam int ROW_AW      = CH_BITS + SEC_BITS;
    localparam int ROWS        = CHANNELS * SECTIONS;
    localparam int ROW_BITS    = 4 * INT_BITS;
    localparam int COEF_DEPTH  = SECTIONS * NCOEF;
    localparam int COEF_AW     = $clog2(COEF_DEPTH);
    localparam int PROD_BITS   = COEF_BITS + INT_BITS;
    localparam int ACC_BITS    = PROD_BITS + 3;
    localparam int STEP_BITS   = 3;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd1048576;

    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_GAIN   = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_COEF    = 2'd1,
        OP_CLR_SEC = 2'd2,
        OP_CLR_ALL = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR_ALL,
        ST_CLR_SEC,
        ST_PRE,
        ST_SEC,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]                    operation;
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [SEC_BITS-1:0]           section;
        logic [SEL_BITS-1:0]           coeff_select;
        logic signed [COEF_BITS-1:0]   coeff_value;
    } t_in_word;

    typedef struct packed {
        logic [CH_BITS-1:0]            out_channel;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          clipped;
    } t_out_word;

    typedef struct packed {
        logic mul_en;
        logic acc_ld;
        logic acc_add;
        logic acc_sub;
    } t_mac_ctrl;

endpackage

// File: sv/bce_coef_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coefficient store
// One word per coefficient, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bce_coef_store (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [bce_pkg::COEF_AW-1:0]         i_waddr,
    input  logic signed [bce_pkg::COEF_BITS-1:0] i_wdata,
    input  logic                                i_re,
    input  logic [bce_pkg::COEF_AW-1:0]         i_raddr,
    output logic signed [bce_pkg::COEF_BITS-1:0] o_rdata
);
    import bce_pkg::*;

    logic signed [COEF_BITS-1:0] r_mem [COEF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: sv/bce_delay_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay store
// One row per channel and section holding the four delay values.
// ----------------------------------------------------------------------------
module bce_delay_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [bce_pkg::ROW_AW-1:0]    i_waddr,
    input  logic [bce_pkg::ROW_BITS-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [bce_pkg::ROW_AW-1:0]    i_raddr,
    output logic [bce_pkg::ROW_BITS-1:0]  o_rdata
);
    import bce_pkg::*;

    logic [ROW_BITS-1:0] r_mem [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: sv/bce_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply accumulate unit
// Shared multiplier with accumulator and the two rounding scalers.
// ----------------------------------------------------------------------------
module bce_mac (
    input  logic                                 i_clk,
    input  bce_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [bce_pkg::COEF_BITS-1:0] i_a,
    input  logic signed [bce_pkg::INT_BITS-1:0]  i_b,
    output logic signed [bce_pkg::INT_BITS-1:0]  o_pre_v,
    output logic                                 o_pre_clip,
    output logic signed [bce_pkg::INT_BITS-1:0]  o_sec_y,
    output logic                                 o_sec_clip
);
    import bce_pkg::*;

    localparam logic signed [ACC_BITS-1:0] INT_MAX =
        $signed({{(ACC_BITS-INT_BITS+1){1'b0}}, {(INT_BITS-1){1'b1}}});
    localparam logic signed [ACC_BITS-1:0] INT_MIN =
        $signed({{(ACC_BITS-INT_BITS+1){1'b1}}, {(INT_BITS-1){1'b0}}});
    localparam logic signed [ACC_BITS-1:0] PRE_HALF =
        $signed({{(ACC_BITS-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}});
    localparam logic signed [ACC_BITS-1:0] SEC_HALF =
        $signed({{(ACC_BITS-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}});

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  w_prod_ext;
    logic signed [ACC_BITS-1:0]  w_pre_sh;
    logic signed [ACC_BITS-1:0]  w_sec_sh;

    assign w_prod_ext = {{(ACC_BITS-PROD_BITS){r_prod[PROD_BITS-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctrl.acc_ld) begin
            r_acc <= w_prod_ext;
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + w_prod_ext;
        end else if (i_ctrl.acc_sub) begin
            r_acc <= r_acc - w_prod_ext;
        end
    end

    always_comb begin
        w_pre_sh = (r_acc + PRE_HALF) >>> GAIN_FRAC;
        w_sec_sh = (r_acc + SEC_HALF) >>> COEF_FRAC;
        o_pre_clip = 1'b1;
        o_sec_clip = 1'b1;
        if (w_pre_sh > INT_MAX) begin
            o_pre_v = INT_MAX[INT_BITS-1:0];
        end else if (w_pre_sh < INT_MIN) begin
            o_pre_v = INT_MIN[INT_BITS-1:0];
        end else begin
            o_pre_v    = w_pre_sh[INT_BITS-1:0];
            o_pre_clip = 1'b0;
        end
        if (w_sec_sh > INT_MAX) begin
            o_sec_y = INT_MAX[INT_BITS-1:0];
        end else if (w_sec_sh < INT_MIN) begin
            o_sec_y = INT_MIN[INT_BITS-1:0];
        end else begin
            o_sec_y    = w_sec_sh[INT_BITS-1:0];
            o_sec_clip = 1'b0;
        end
    end

endmodule

// File: sv/biquad_cascade_equalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade equalizer
// Multichannel chain of direct form I biquads over coefficient and delay RAMs.
// ----------------------------------------------------------------------------
// Channel  | Ports                          | Direction
// input    | i_valid, o_stall, i_word       | in
// output   | o_valid, i_stall, o_word       | out
// config   | i_cfg_we, i_cfg_index, i_cfg_data | in
//
// For each of the n active sections of a sample word, one shared
// multiplier computes the five products of the section in turn.
// A section clear covers its 8 channel rows; a full clear covers all 512 rows.
// After reset a pass over all rows clears the delay RAM; o_stall is high meanwhile.
// A result waits in the output register; a stalled result holds the next one back.
// ----------------------------------------------------------------------------
module biquad_cascade_equalizer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  bce_pkg::t_in_word                i_word,
    output logic                             o_valid,
    input  logic                             i_stall,
    output bce_pkg::t_out_word               o_word,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [bce_pkg::GAIN_BITS-1:0]    i_cfg_data
);
    import bce_pkg::*;

    t_state                      r_state, n_state;
    logic [ROW_AW-1:0]           r_cnt;
    logic [STEP_BITS-1:0]        r_step;
    logic [SEC_BITS-1:0]         r_sec;
    logic [SEC_BITS-1:0]         r_sec_clr;
    logic [CH_BITS-1:0]          r_ch;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [INT_BITS-1:0]  r_v;
    logic                        r_clip;
    logic [ACT_BITS-1:0]         r_active;
    logic [GAIN_BITS-1:0]        r_gain;

    logic                        w_accept;
    logic                        w_out_free;
    logic [ACT_BITS-1:0]         w_nlim;
    logic                        w_last_sec;
    t_mac_ctrl                   w_mac;
    logic signed [COEF_BITS-1:0] w_mul_a;
    logic signed [INT_BITS-1:0]  w_mul_b;
    logic                        w_coef_we;
    logic [COEF_AW-1:0]          w_coef_waddr;
    logic                        w_coef_re;
    logic [COEF_AW-1:0]          w_coef_raddr;
    logic signed [COEF_BITS-1:0] w_coef_q;
    logic                        w_dly_we;
    logic [ROW_AW-1:0]           w_dly_waddr;
    logic [ROW_BITS-1:0]         w_dly_wdata;
    logic                        w_dly_re;
    logic [ROW_BITS-1:0]         w_dly_q;
    logic signed [INT_BITS-1:0]  w_pre_v;
    logic                        w_pre_clip;
    logic signed [INT_BITS-1:0]  w_sec_y;
    logic                        w_sec_clip;
    logic                        w_out_sat;
    logic signed [SAMPLE_BITS-1:0] w_out_s;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !o_valid || !i_stall;
    assign w_nlim     = (r_active > ACT_BITS'(SECTIONS)) ? ACT_BITS'(SECTIONS) : r_active;
    assign w_last_sec = ({1'b0, r_sec} + ACT_BITS'(1)) == w_nlim;

    bce_coef_store u_coef (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (i_word.coeff_value),
        .i_re    (w_coef_re),
        .i_raddr (w_coef_raddr),
        .o_rdata (w_coef_q)
    );

    bce_delay_store u_delay (
        .i_clk   (i_clk),
        .i_we    (w_dly_we),
        .i_waddr (w_dly_waddr),
        .i_wdata (w_dly_wdata),
        .i_re    (w_dly_re),
        .i_raddr ({r_ch, r_sec}),
        .o_rdata (w_dly_q)
    );

    bce_mac u_mac (
        .i_clk      (i_clk),
        .i_ctrl     (w_mac),
        .i_a        (w_mul_a),
        .i_b        (w_mul_b),
        .o_pre_v    (w_pre_v),
        .o_pre_clip (w_pre_clip),
        .o_sec_y    (w_sec_y),
        .o_sec_clip (w_sec_clip)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_word.operation))
                        OP_SAMPLE:  n_state = ST_PRE;
                        OP_CLR_SEC: n_state = ST_CLR_SEC;
                        OP_CLR_ALL: n_state = ST_CLR_ALL;
                        OP_COEF:    n_state = ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLR_ALL: begin
                if (r_cnt == ROW_AW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLR_SEC: begin
                if (r_cnt[CH_BITS-1:0] == CH_BITS'(CHANNELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PRE: begin
                if (r_step == STEP_BITS'(2)) begin
                    n_state = (w_nlim == '0) ? ST_FIN : ST_SEC;
                end
            end
            ST_SEC: begin
                if (r_step == STEP_BITS'(7) && w_last_sec) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_mac        = '0;
        w_mul_a      = w_coef_q;
        w_mul_b      = r_v;
        w_coef_we    = 1'b0;
        w_coef_waddr = COEF_AW'({i_word.section, 2'b00}) + COEF_AW'(i_word.section)
                       + COEF_AW'(i_word.coeff_select);
        w_coef_re    = 1'b0;
        w_coef_raddr = COEF_AW'({r_sec, 2'b00}) + COEF_AW'(r_sec) + COEF_AW'(r_step);
        w_dly_we     = 1'b0;
        w_dly_waddr  = r_cnt;
        w_dly_wdata  = '0;
        w_dly_re     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_coef_we = w_accept && (i_word.operation == OP_COEF)
                            && (i_word.coeff_select < SEL_BITS'(NCOEF));
            end
            ST_CLR_ALL: begin
                w_dly_we = 1'b1;
            end
            ST_CLR_SEC: begin
                w_dly_we    = 1'b1;
                w_dly_waddr = {r_cnt[CH_BITS-1:0], r_sec_clr};
            end
            ST_PRE: begin
                w_mul_a       = {{(COEF_BITS-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
                w_mul_b       = $signed({{(INT_BITS-GAIN_BITS){1'b0}}, r_gain});
                w_mac.mul_en  = (r_step == STEP_BITS'(0));
                w_mac.acc_ld  = (r_step == STEP_BITS'(1));
            end
            ST_SEC: begin
                w_coef_re = (r_step < STEP_BITS'(NCOEF));
                w_dly_re  = (r_step == STEP_BITS'(0));
                unique case (r_step)
                    STEP_BITS'(1): w_mul_b = r_v;
                    STEP_BITS'(2): w_mul_b = w_dly_q[0*INT_BITS +: INT_BITS];
                    STEP_BITS'(3): w_mul_b = w_dly_q[1*INT_BITS +: INT_BITS];
                    STEP_BITS'(4): w_mul_b = w_dly_q[2*INT_BITS +: INT_BITS];
                    STEP_BITS'(5): w_mul_b = w_dly_q[3*INT_BITS +: INT_BITS];
                    default:       w_mul_b = r_v;
                endcase
                w_mac.mul_en  = (r_step >= STEP_BITS'(1)) && (r_step <= STEP_BITS'(5));
                w_mac.acc_ld  = (r_step == STEP_BITS'(2));
                w_mac.acc_add = (r_step == STEP_BITS'(3)) || (r_step == STEP_BITS'(4));
                w_mac.acc_sub = (r_step == STEP_BITS'(5)) || (r_step == STEP_BITS'(6));
                w_dly_we      = (r_step == STEP_BITS'(7));
                w_dly_waddr   = {r_ch, r_sec};
                w_dly_wdata   = {w_dly_q[2*INT_BITS +: INT_BITS], w_sec_y,
                                 w_dly_q[0 +: INT_BITS], r_v};
            end
            ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_out_sat = (r_v[INT_BITS-1:SAMPLE_BITS-1] != '0)
                    && (r_v[INT_BITS-1:SAMPLE_BITS-1] != '1);
        if (!w_out_sat) begin
            w_out_s = r_v[SAMPLE_BITS-1:0];
        end else if (r_v[INT_BITS-1]) begin
            w_out_s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_out_s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR_ALL;
            r_cnt    <= '0;
            r_step   <= '0;
            r_sec    <= '0;
            r_active <= '0;
            r_gain   <= GAIN_RESET;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ACTIVE) begin
                    r_active <= i_cfg_data[ACT_BITS-1:0];
                end else begin
                    r_gain <= i_cfg_data;
                end
            end
            if ((r_state == ST_FIN) && w_out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt  <= '0;
                    r_step <= '0;
                    if (w_accept) begin
                        r_ch      <= i_word.channel;
                        r_x       <= i_word.sample_in;
                        r_sec_clr <= i_word.section;
                    end
                end
                ST_CLR_ALL, ST_CLR_SEC: begin
                    r_cnt <= r_cnt + ROW_AW'(1);
                end
                ST_PRE: begin
                    if (r_step == STEP_BITS'(2)) begin
                        r_v    <= w_pre_v;
                        r_clip <= w_pre_clip;
                        r_step <= '0;
                        r_sec  <= '0;
                    end else begin
                        r_step <= r_step + STEP_BITS'(1);
                    end
                end
                ST_SEC: begin
                    r_step <= r_step + STEP_BITS'(1);
                    if (r_step == STEP_BITS'(7)) begin
                        r_v    <= w_sec_y;
                        r_clip <= r_clip | w_sec_clip;
                        r_sec  <= r_sec + SEC_BITS'(1);
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        o_word.out_channel <= r_ch;
                        o_word.sample_out  <= w_out_s;
                        o_word.clipped     <= r_clip | w_out_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: sv/bce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equalizer port checker
// Watches the equalizer ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module bce_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input bce_pkg::t_in_word  i_word,
    input logic               o_valid,
    input logic               i_stall,
    input bce_pkg::t_out_word o_word
);
    import bce_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("Stalled output word changed.");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("Block not busy clearing after reset.");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_word.operation == OP_SAMPLE) |=> o_stall)
        else $error("Block not busy after taking a sample word.");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("Result appeared the cycle after an input word.");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("Block still busy when its result was issued.");

endmodule

bind biquad_cascade_equalizer_unit bce_checker u_bce_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_word  (i_word),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);

// File: verif/tb_biquad_cascade_equalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade equalizer testbench
// Drives sample, coefficient and clear words under random handshake gaps,
// predicts every filtered sample in fixed point and checks each result word.
// ----------------------------------------------------------------------------
module tb_biquad_cascade_equalizer_unit;
    import bce_pkg::*;

    class eq_scoreboard;
        logic signed [COEF_BITS-1:0] coefs[COEF_DEPTH];
        logic signed [INT_BITS-1:0]  taps[CHANNELS][SECTIONS][4];
        logic [ACT_BITS-1:0]         n_active;
        logic [GAIN_BITS-1:0]        gain;
        t_out_word                   pending[$];
        int                          errors;
        int                          n_checked;

        function new();
            errors = 0;
            n_checked = 0;
            n_active = '0;
            gain = GAIN_RESET;
            foreach (coefs[i]) coefs[i] = '0;
            foreach (taps[c, s, k]) taps[c][s][k] = '0;
        endfunction

        function void set_reg(logic idx, logic [GAIN_BITS-1:0] data);
            if (idx == CFG_ACTIVE) n_active = data[ACT_BITS-1:0];
            else gain = data;
        endfunction

        function logic signed [INT_BITS-1:0] sat_int(logic signed [127:0] v, ref bit clip);
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            hi = (128'sd1 <<< (INT_BITS - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                clip = 1;
                return hi[INT_BITS-1:0];
            end
            if (v < lo) begin
                clip = 1;
                return lo[INT_BITS-1:0];
            end
            return v[INT_BITS-1:0];
        endfunction

        function void note_input(t_in_word w);
            logic signed [127:0] v;
            logic signed [127:0] acc;
            logic signed [INT_BITS-1:0] y;
            logic signed [INT_BITS-1:0] cur;
            t_out_word r;
            bit clip;
            int n;
            int b;
            case (t_op'(w.operation))
                OP_COEF: begin
                    if (w.coeff_select < NCOEF)
                        coefs[w.section * NCOEF + w.coeff_select] = w.coeff_value;
                end
                OP_CLR_SEC: begin
                    for (int c = 0; c < CHANNELS; c++)
                        for (int k = 0; k < 4; k++) taps[c][w.section][k] = '0;
                end
                OP_CLR_ALL: begin
                    foreach (taps[c, s, k]) taps[c][s][k] = '0;
                end
                default: begin
                    clip = 0;
                    n = (n_active > SECTIONS) ? SECTIONS : n_active;
                    v = $signed(w.sample_in) * $signed({1'b0, gain})
                        + (128'sd1 <<< (GAIN_FRAC - 1));
                    v = v >>> GAIN_FRAC;
                    cur = sat_int(v, clip);
                    for (int i = 0; i < n; i++) begin
                        b = i * NCOEF;
                        acc = $signed(coefs[b]) * cur
                            + $signed(coefs[b+1]) * taps[w.channel][i][0]
                            + $signed(coefs[b+2]) * taps[w.channel][i][1]
                            - $signed(coefs[b+3]) * taps[w.channel][i][2]
                            - $signed(coefs[b+4]) * taps[w.channel][i][3];
                        acc = (acc + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
                        y = sat_int(acc, clip);
                        taps[w.channel][i][1] = taps[w.channel][i][0];
                        taps[w.channel][i][0] = cur;
                        taps[w.channel][i][3] = taps[w.channel][i][2];
                        taps[w.channel][i][2] = y;
                        cur = y;
                    end
                    r.out_channel = w.channel;
                    if (cur > 32'sd8388607) begin
                        clip = 1;
                        r.sample_out = 24'h7FFFFF;
                    end else if (cur < -32'sd8388608) begin
                        clip = 1;
                        r.sample_out = 24'h800000;
                    end else begin
                        r.sample_out = cur[SAMPLE_BITS-1:0];
                    end
                    r.clipped = clip;
                    pending.push_back(r);
                end
            endcase
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            n_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.out_channel !== exp_w.out_channel) begin
                $display("%0t: out_channel expected %0d actual %0d", $time,
                         exp_w.out_channel, got.out_channel);
                errors++;
            end
            if (got.sample_out !== exp_w.sample_out) begin
                $display("%0t: sample_out expected %h actual %h", $time,
                         exp_w.sample_out, got.sample_out);
                errors++;
            end
            if (got.clipped !== exp_w.clipped) begin
                $display("%0t: clipped expected %0d actual %0d", $time,
                         exp_w.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in_word i_word;
    logic o_valid;
    logic i_stall;
    t_out_word o_word;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [GAIN_BITS-1:0] i_cfg_data;

    eq_scoreboard board;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    int n_sent;

    biquad_cascade_equalizer_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_word);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(w);
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [GAIN_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic t_in_word rand_word(int max_sec);
        t_in_word w;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        w = bits[$bits(t_in_word)-1:0];
        case ($urandom_range(99))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                w.operation = OP_COEF;
                w.section = SEC_BITS'($urandom_range(SECTIONS - 1));
                if (w.section < max_sec) begin
                    w.coeff_value = $signed($urandom) >>> $urandom_range(8, 2);
                end
            end
            12, 13, 14: w.operation = OP_CLR_SEC;
            15: w.operation = OP_CLR_ALL;
            default: begin
                w.operation = OP_SAMPLE;
                if ($urandom_range(9) == 0)
                    w.sample_in = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            end
        endcase
        return w;
    endfunction

    function automatic t_in_word coef_word(int sec, int sel, int val);
        t_in_word w;
        w = '0;
        w.operation = OP_COEF;
        w.section = SEC_BITS'(sec);
        w.coeff_select = SEL_BITS'(sel);
        w.coeff_value = val;
        return w;
    endfunction

    task automatic run_phase(int count, int sec_n);
        for (int i = 0; i < count; i++) send_word(rand_word(sec_n));
        drain();
    endtask

    initial begin
        t_in_word w;
        board = new();
        i_rst_n = 0;
        i_valid = 0;
        i_word = '0;
        i_stall = 0;
        i_cfg_we = 0;
        i_cfg_index = 0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        n_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every coefficient gets a stable value before any section runs.
        for (int s = 0; s < SECTIONS; s++)
            for (int k = 0; k < NCOEF; k++)
                board.note_input(coef_word(s, k, 0));
        for (int s = 0; s < SECTIONS; s++) begin
            send_word(coef_word(s, 0, 32'sh0400_0000));
            send_word(coef_word(s, 1, $signed($urandom) >>> 6));
            send_word(coef_word(s, 2, $signed($urandom) >>> 6));
            send_word(coef_word(s, 3, $signed($urandom) >>> 6));
            send_word(coef_word(s, 4, $signed($urandom) >>> 6));
        end

        // Directed: zero sections, full scale samples, invalid selects, clears.
        w = '0;
        w.sample_in = 24'h7FFFFF;
        send_word(w);
        w.sample_in = 24'h800000;
        w.channel = 3'd7;
        send_word(w);
        drain();
        write_reg(CFG_GAIN, 24'hFFFFFF);
        write_reg(CFG_ACTIVE, 24'd2);
        send_word(w);
        w.sample_in = 24'h7FFFFF;
        send_word(w);
        send_word(coef_word(1, 5, -1));
        send_word(coef_word(1, 7, 32'sh7FFF_FFFF));
        send_word(coef_word(0, 0, 32'sh8000_0000));
        w.operation = OP_CLR_SEC;
        w.section = 6'd63;
        send_word(w);
        w.operation = OP_CLR_ALL;
        send_word(w);
        w.operation = OP_SAMPLE;
        send_word(w);
        send_word(coef_word(0, 0, 32'sh7FFF_FFFF));
        send_word(w);
        send_word(coef_word(0, 0, 32'sh0400_0000));
        drain();
        write_reg(CFG_GAIN, '0);
        write_reg(CFG_ACTIVE, 24'd127);
        send_word(w);
        drain();

        write_reg(CFG_GAIN, GAIN_RESET);
        write_reg(CFG_ACTIVE, 24'd3);
        run_phase(120, 64);
        send_idle_pct = 77;
        write_reg(CFG_ACTIVE, 24'd1);
        write_reg(CFG_GAIN, 24'h0C0000);
        run_phase(120, 64);
        send_idle_pct = 0;
        stall_pct = 77;
        write_reg(CFG_ACTIVE, 24'd0);
        write_reg(CFG_GAIN, 24'h3FFFFF);
        run_phase(100, 64);
        send_idle_pct = 24;
        stall_pct = 24;
        write_reg(CFG_ACTIVE, 24'd4);
        write_reg(CFG_GAIN, GAIN_BITS'($urandom_range(24'hFFFFFF)));
        run_phase(100, 64);
        stall_pct = 0;
        send_idle_pct = 0;
        write_reg(CFG_ACTIVE, 24'd64);
        write_reg(CFG_GAIN, GAIN_RESET);
        hold_cycles = 3000;
        run_phase(40, 64);
        write_reg(CFG_ACTIVE, 24'd65);
        run_phase(20, 64);

        $display("Sent %0d words and checked %0d filtered samples under varied flow control.",
                 n_sent, board.n_checked);
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: sim.f
sv/bce_pkg.sv
sv/bce_coef_store.sv
sv/bce_delay_store.sv
sv/bce_mac.sv
sv/biquad_cascade_equalizer_unit.sv
sv/bce_checker.sv
verif/tb_biquad_cascade_equalizer_unit.sv
